@@ src/cwi_pkg.sv @@
// Shared widths and constants for the capacity weight square root block.
package cwi_pkg;

  localparam int unsigned FREE_W   = 64;
  localparam int unsigned WEIGHT_W = 22;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

endpackage

@@ src/cwi_sqrt_core.sv @@
// Bit-pair floor square root unit: one trial subtract per clock cycle.
module cwi_sqrt_core
  import cwi_pkg::*;
#(
  parameter int unsigned UW = 44
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [UW-1:0]           units,
  output logic                    done,
  output logic [(UW+1)/2-1:0]     root
);

  localparam int unsigned NP = (UW + 1) / 2;
  localparam int unsigned RW = 2 * NP;
  localparam int unsigned CW = $clog2(NP + 1);

  logic          run_r,  run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [RW-1:0] rem_r,  rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [RW-1:0] pair_r, pair_nxt;
  logic [RW:0]   trial;

  // Trial value for the current bit pair
  assign trial = {1'b0, root_r} + {1'b0, pair_r};

  // Load on start, then retire one bit pair per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    pair_nxt = pair_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = CW'(NP - 1);
      rem_nxt  = RW'(units);
      root_nxt = '0;
      pair_nxt = RW'(1) << (RW - 2);
    end else if (run_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt  = rem_r - trial[RW-1:0];
        root_nxt = (root_r >> 1) + pair_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      pair_nxt = pair_r >> 2;
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset; datapath needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    pair_r <= pair_nxt;
  end

  assign done = done_r;
  assign root = root_r[NP-1:0];

endmodule

@@ src/capacity_weight_isqrt_top.sv @@
// Capacity weight: floor square root of free storage counted in whole units.
// Items of one unit or more run through the one-pair-per-cycle subtract loop in the root unit;
// busy is high from the transfer until the strobe.
// An item under one unit gives its strobe in the cycle after transfer, busy stays low.
// No new item is taken while busy; the next transfer is taken at the edge that ends the strobe;
// items under one unit go one per cycle while the block is idle.
// Results are shown for one cycle, the receiver cannot stall.
// Reset (rst_n low, synchronous) drops any item in flight and clears busy and out_valid.
module capacity_weight_isqrt_top
  import cwi_pkg::*;
#(
  parameter int unsigned UNIT_SHIFT  = 20,
  parameter int unsigned INPUT_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FREE_W-1:0]   in_free_bytes,
  output logic                out_valid,
  output logic [WEIGHT_W-1:0] out_weight
);

  localparam int unsigned UW = (INPUT_WIDTH > UNIT_SHIFT) ? (INPUT_WIDTH - UNIT_SHIFT) : 1;
  localparam int unsigned NP = (UW + 1) / 2;
  localparam logic [FREE_W-1:0] IN_MASK =
    (INPUT_WIDTH >= FREE_W) ? {FREE_W{1'b1}} : ((FREE_W'(1) << INPUT_WIDTH) - FREE_W'(1));

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;

  logic [FREE_W-1:0]   bytes_m;
  logic [FREE_W-1:0]   units_w;
  logic                accept;
  logic                units_zero;
  logic                core_start;
  logic                core_done;
  logic [NP-1:0]       core_root;
  logic [FREE_W-1:0]   root_ext;

  // Drop bits above the input width, then the sub-unit bits
  assign bytes_m    = in_free_bytes & IN_MASK;
  assign units_w    = (UNIT_SHIFT >= FREE_W) ? '0 : (bytes_m >> UNIT_SHIFT);
  assign units_zero = (units_w == '0);
  assign accept     = start && (state_r == ST_IDLE);
  assign core_start = accept && !units_zero;
  assign root_ext   = FREE_W'(core_root);

  cwi_sqrt_core #(
    .UW (UW)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .units (units_w[UW-1:0]),
    .done  (core_done),
    .root  (core_root)
  );

  // Sequence one transfer through the root unit; short-cut items under one unit
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_weight_nxt = out_weight_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (units_zero) begin
            out_valid_nxt  = 1'b1;
            out_weight_nxt = WEIGHT_W'(bytes_m != '0);
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (core_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (root_ext > FREE_W'(WEIGHT_MAX)) begin
            out_weight_nxt = WEIGHT_MAX;
          end else begin
            out_weight_nxt = root_ext[WEIGHT_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_weight_r <= out_weight_nxt;
  end

  assign busy       = (state_r == ST_RUN);
  assign out_valid  = out_valid_r;
  assign out_weight = out_weight_r;

endmodule

@@ dv/capacity_weight_isqrt_top_tb.sv @@
// Self-checking testbench for the capacity weight square root block.
module capacity_weight_isqrt_top_tb;
  import cwi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UNIT_SHIFT  = 20;
  localparam int unsigned INPUT_WIDTH = 64;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct {
    logic [FREE_W-1:0] bytes;
    int unsigned       lead;
  } free_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FREE_W-1:0]   in_free_bytes = '0;
  logic                out_valid;
  logic [WEIGHT_W-1:0] out_weight;

  free_item_t          feed_q[$];
  logic [WEIGHT_W-1:0] expected_weights[$];
  int unsigned         lead_count = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;

  capacity_weight_isqrt_top #(
    .UNIT_SHIFT (UNIT_SHIFT),
    .INPUT_WIDTH(INPUT_WIDTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_free_bytes(in_free_bytes),
    .out_valid    (out_valid),
    .out_weight   (out_weight)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor square root of whole units, one bit pair per step; small nonzero counts give one
  function automatic logic [WEIGHT_W-1:0] capacity_weight(input logic [FREE_W-1:0] free_bytes);
    logic [63:0] mask;
    logic [63:0] bytes;
    logic [63:0] units;
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] bit_pair;
    logic [63:0] trial;
    mask = (INPUT_WIDTH >= 64) ? '1 : ((64'd1 << INPUT_WIDTH) - 64'd1);
    bytes = free_bytes & mask;
    units = bytes >> UNIT_SHIFT;
    if (units == 0) begin
      return (bytes != 0) ? WEIGHT_W'(1) : WEIGHT_W'(0);
    end
    rest = units;
    root = '0;
    bit_pair = 64'd1 << 62;
    while (bit_pair > rest) bit_pair = bit_pair >> 2;
    while (bit_pair != 0) begin
      trial = root + bit_pair;
      if (rest >= trial) begin
        rest = rest - trial;
        root = (root >> 1) + bit_pair;
      end else begin
        root = root >> 1;
      end
      bit_pair = bit_pair >> 2;
    end
    if (root > 64'(WEIGHT_MAX)) root = 64'(WEIGHT_MAX);
    return root[WEIGHT_W-1:0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random byte count from a mix of sub-unit, full-width, sized and near-square values
  function automatic logic [63:0] random_free_bytes();
    logic [63:0] value;
    logic [63:0] units;
    logic [63:0] root;
    int unsigned nbits;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      value = rand64() & ((64'd1 << UNIT_SHIFT) - 1);
      if ($urandom_range(0, 15) == 0) value = 64'($urandom_range(0, 1));
    end else if (pick < 45) begin
      value = rand64();
    end else if (pick < 75) begin
      nbits = $urandom_range(1, 64);
      value = rand64();
      if (nbits < 64) value = value & ((64'd1 << nbits) - 1);
      value[nbits-1] = 1'b1;
    end else begin
      nbits = $urandom_range(1, WEIGHT_W);
      root = 64'($urandom) & ((64'd1 << nbits) - 1);
      units = root * root;
      case ($urandom_range(0, 2))
        0: if (units != 0) units = units - 1;
        1: units = units + 1;
        default: ;
      endcase
      units = units & ((64'd1 << (64 - UNIT_SHIFT)) - 1);
      case ($urandom_range(0, 2))
        0: value = units << UNIT_SHIFT;
        1: value = (units << UNIT_SHIFT) | ((64'd1 << UNIT_SHIFT) - 1);
        default: value = (units << UNIT_SHIFT) | (rand64() & ((64'd1 << UNIT_SHIFT) - 1));
      endcase
    end
    return value;
  endfunction

  // Drive one transfer at a time; record the expected weight as each one is taken
  always @(posedge clk) begin
    logic took;
    if (!rst_n) begin
      start <= 1'b0;
      lead_count = 0;
    end else begin
      took = start && !busy;
      if (took) expected_weights.push_back(capacity_weight(in_free_bytes));
      if (!start || took) begin
        if (feed_q.size() != 0 && lead_count >= feed_q[0].lead) begin
          start <= 1'b1;
          in_free_bytes <= feed_q[0].bytes;
          feed_q.pop_front();
          lead_count = 0;
        end else begin
          start <= 1'b0;
          if (feed_q.size() != 0) lead_count++;
        end
      end
    end
  end

  // Compare each strobed weight with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_weights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("unexpected weight %0d with nothing pending", out_weight);
      end else begin
        if (out_weight !== expected_weights[0]) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("weight mismatch: expected %0d got %0d", expected_weights[0], out_weight);
        end
        expected_weights.pop_front();
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("capacity_weight_isqrt_top test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] directed[$];
    free_item_t  item;
    int unsigned burst_left;
    bit          no_gaps;
    // Extremes, unit boundary, square boundaries and widest root
    directed = '{
      64'd0, 64'd1, 64'h0000_0000_000F_FFFF, 64'h0000_0000_0010_0000,
      64'h0000_0000_0010_0001, 64'h0000_0000_003F_FFFF, 64'h0000_0000_0040_0000,
      64'h0000_0000_0090_0000, 64'h0000_0000_008F_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      (64'(22'h3FFFFF) * 64'(22'h3FFFFF)) << UNIT_SHIFT,
      ((64'(22'h3FFFFF) * 64'(22'h3FFFFF)) << UNIT_SHIFT) - 64'd1,
      64'h0000_0100_0000_0000, 64'h0000_00FF_FFFF_FFFF,
      64'h4000_0000_0000_0000, 64'h0000_0000_8000_0000
    };
    foreach (directed[i]) begin
      item.bytes = directed[i];
      item.lead = $urandom_range(0, 10);
      feed_q.push_back(item);
    end
    // Random items in bursts, some with no idle cycles at all
    burst_left = 0;
    no_gaps = 1'b0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      burst_left--;
      item.bytes = random_free_bytes();
      item.lead = no_gaps ? 0 : $urandom_range(0, 10);
      feed_q.push_back(item);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then allow for stray strobes
    do @(posedge clk);
    while (feed_q.size() != 0 || start || expected_weights.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    // Any weight still pending was never strobed
    if (mismatch_count == 0 && expected_weights.size() == 0) begin
      $display("capacity_weight_isqrt_top test passed");
    end else begin
      $display("capacity_weight_isqrt_top test failed");
    end
    $finish;
  end

endmodule
